@@ rtl/hcbp_pkg.sv @@
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants of the Huffman code bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int SYMBOL_COUNT_DEF = 256;

  localparam int KIND_W   = 2;
  localparam int SYMBOL_W = 8;
  localparam int LEN_W    = 6;
  localparam int CODE_W   = 32;
  localparam int BYTE_W   = 8;
  localparam int PAD_W    = 3;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_t;

  // work handed from the front end to the back end, code left-aligned
  typedef struct packed {
    logic              flush;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } job_t;

  typedef enum logic {
    BK_IDLE,
    BK_SHIFT
  } back_state_t;

endpackage

`default_nettype wire

@@ rtl/hcbp_if.sv @@
// ----------------------------------------------------------------------------
// hcbp_in_if / hcbp_out_if
// Valid/ready channels carrying input words and packed output bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcbp_in_if;
  import hcbp_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SYMBOL_W-1:0] symbol;
  logic [LEN_W-1:0]    code_length;
  logic [CODE_W-1:0]   code_bits;

  modport source (output valid, output kind, output symbol, output code_length,
                  output code_bits, input ready);
  modport sink (input valid, input kind, input symbol, input code_length,
                input code_bits, output ready);
endinterface

interface hcbp_out_if;
  import hcbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] packed_byte;
  logic [PAD_W-1:0]  pad_bits;
  logic              last;

  modport source (output valid, output packed_byte, output pad_bits, output last,
                  input ready);
  modport sink (input valid, input packed_byte, input pad_bits, input last,
                output ready);
endinterface

`default_nettype wire

@@ rtl/hcbp_front.sv @@
// ----------------------------------------------------------------------------
// hcbp_front
// Accepts words, keeps the code table and turns flush words and encode words
// with a non-zero code length into jobs for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_front #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  hcbp_in_if.sink        items,
  output logic           job_push,
  output hcbp_pkg::job_t job,
  input  logic           job_ready
);
  import hcbp_pkg::*;

  localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int TLEN_W  = $clog2(LEN_CAP + 1);
  localparam int SYM_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int WORD_W  = TLEN_W + CODE_W;

  logic [WORD_W-1:0]       mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] loaded;

  logic [WORD_W-1:0]  rd_word;
  logic               s1_valid;
  logic               s1_hit;
  logic [KIND_W-1:0]  s1_kind;

  logic               accept;
  logic               in_range;
  logic [SYM_W-1:0]   idx;
  logic [TLEN_W-1:0]  load_len;
  logic               keep;
  logic [LEN_W-1:0]   eff_len;
  logic [CODE_W-1:0]  rd_code;
  logic               useful;
  logic               s1_free;

  assign in_range = {1'b0, items.symbol} < (SYMBOL_W + 1)'(SYMBOL_COUNT);
  assign idx      = items.symbol[SYM_W-1:0];
  assign accept   = items.valid && items.ready;
  assign load_len = (items.code_length > LEN_W'(LEN_CAP)) ? TLEN_W'(LEN_CAP)
                                                          : items.code_length[TLEN_W-1:0];
  assign keep     = (items.kind == KIND_ENCODE) || (items.kind == KIND_FLUSH);

  always_ff @(posedge clk) begin
    if (accept && (items.kind == KIND_LOAD) && in_range) begin
      mem[idx] <= {load_len, items.code_bits};
    end
    if (accept) begin
      rd_word <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded   <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept && (items.kind == KIND_LOAD) && in_range) begin
        loaded[idx] <= 1'b1;
      end
      if (s1_free) begin
        s1_valid <= accept && keep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind <= items.kind;
      s1_hit  <= in_range && loaded[idx];
    end
  end

  assign rd_code  = rd_word[CODE_W-1:0];
  assign eff_len  = s1_hit ? LEN_W'(rd_word[CODE_W +: TLEN_W]) : '0;
  assign useful   = (s1_kind == KIND_FLUSH) || ((s1_kind == KIND_ENCODE) && (eff_len != '0));
  assign s1_free  = !s1_valid || !useful || job_ready;
  assign items.ready = s1_free;

  assign job_push   = s1_valid && useful;
  assign job.flush  = (s1_kind == KIND_FLUSH);
  assign job.len    = eff_len;
  assign job.code   = rd_code << (LEN_W'(CODE_W) - eff_len);

endmodule

`default_nettype wire

@@ rtl/hcbp_queue.sv @@
// ----------------------------------------------------------------------------
// hcbp_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hcbp_pkg::job_t push_job,
  output logic           ready,
  output logic           valid,
  output hcbp_pkg::job_t head,
  input  logic           pop
);
  import hcbp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign ready   = count != CNT_W'(QUEUE_DEPTH);
  assign valid   = count != '0;
  assign head    = slots[rd_ptr];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/hcbp_back.sv @@
// ----------------------------------------------------------------------------
// hcbp_back
// Shifts code bits into the pending byte, up to one byte per cycle while
// the output is free, and registers each completed or flushed byte for output.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  hcbp_pkg::job_t job,
  output logic           job_pop,
  hcbp_out_if.source     results
);
  import hcbp_pkg::*;

  back_state_t       state, state_next;
  logic [BYTE_W-1:0] pending, pending_next;
  logic [2:0]        fill, fill_next;
  logic [LEN_W-1:0]  rem, rem_next;
  logic [CODE_W-1:0] code_sh, code_sh_next;
  logic              out_valid, out_valid_next;
  logic [BYTE_W-1:0] out_byte, out_byte_next;
  logic [PAD_W-1:0]  out_pad, out_pad_next;
  logic              out_last, out_last_next;

  logic              slot_free;
  logic [3:0]        free_bits;
  logic [3:0]        take;
  logic [BYTE_W-1:0] chunk;
  logic [BYTE_W-1:0] merged;
  logic [3:0]        fill_sum;
  logic              full;
  logic [LEN_W-1:0]  rem_after;

  assign slot_free = !out_valid || results.ready;
  assign free_bits = 4'd8 - {1'b0, fill};
  assign take      = (rem < {2'b00, free_bits}) ? rem[3:0] : free_bits;
  assign chunk     = code_sh[CODE_W-1 -: BYTE_W] & ~(8'hFF >> take);
  assign merged    = pending | (chunk >> fill);
  assign fill_sum  = {1'b0, fill} + take;
  assign full      = fill_sum[3];
  assign rem_after = rem - {2'b00, take};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      pending   <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pending   <= pending_next;
      fill      <= fill_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rem      <= rem_next;
    code_sh  <= code_sh_next;
    out_byte <= out_byte_next;
    out_pad  <= out_pad_next;
    out_last <= out_last_next;
  end

  always_comb begin
    state_next     = state;
    pending_next   = pending;
    fill_next      = fill;
    rem_next       = rem;
    code_sh_next   = code_sh;
    out_valid_next = out_valid && !results.ready;
    out_byte_next  = out_byte;
    out_pad_next   = out_pad;
    out_last_next  = out_last;
    job_pop        = 1'b0;
    case (state)
      BK_IDLE: begin
        if (job_valid) begin
          if (job.flush) begin
            if (fill == '0) begin
              job_pop = 1'b1;
            end else if (slot_free) begin
              job_pop        = 1'b1;
              out_valid_next = 1'b1;
              out_byte_next  = pending;
              out_pad_next   = PAD_W'(free_bits);
              out_last_next  = 1'b1;
              pending_next   = '0;
              fill_next      = '0;
            end
          end else begin
            job_pop      = 1'b1;
            code_sh_next = job.code;
            rem_next     = job.len;
            state_next   = BK_SHIFT;
          end
        end
      end
      BK_SHIFT: begin
        if (!full || slot_free) begin
          code_sh_next = code_sh << take;
          rem_next     = rem_after;
          if (full) begin
            out_valid_next = 1'b1;
            out_byte_next  = merged;
            out_pad_next   = '0;
            out_last_next  = rem_after < LEN_W'(BYTE_W);
            pending_next   = '0;
            fill_next      = '0;
          end else begin
            pending_next = merged;
            fill_next    = fill_sum[2:0];
          end
          if (rem_after == '0) begin
            state_next = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  assign results.valid       = out_valid;
  assign results.packed_byte = out_byte;
  assign results.pad_bits    = out_pad;
  assign results.last        = out_last;

endmodule

`default_nettype wire

@@ rtl/huffman_code_bit_packer.sv @@
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Table-driven Huffman encoder back end: code table, bit packer, byte output.
// ----------------------------------------------------------------------------
// Load words write one symbol's code into a table of SYMBOL_COUNT entries;
// encode words append that symbol's code to the pending byte, MSB first,
// and flush words send out a partial byte with its pad count. The front end
// takes one word per cycle while its stage is free (a load is done in that
// cycle) and hands encode and flush work through a two-entry queue to the
// packer. The packer takes a code from the queue in its idle state and then
// moves it chunk by chunk into the pending byte in its shift state; a flush
// is handled in the idle state. Completed bytes leave through an output
// register, one per cycle while the receiver is ready. Code lengths read as
// zero after reset without any clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_bit_packer #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  hcbp_in_if.sink     items,
  hcbp_out_if.source  results
);
  import hcbp_pkg::*;

  logic push;
  job_t push_job;
  logic q_ready;
  logic q_valid;
  job_t head;
  logic pop;

  hcbp_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .job_push  (push),
    .job       (push_job),
    .job_ready (q_ready)
  );

  hcbp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .ready    (q_ready),
    .valid    (q_valid),
    .head     (head),
    .pop      (pop)
  );

  hcbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job       (head),
    .job_pop   (pop),
    .results   (results)
  );

endmodule

`default_nettype wire

@@ tb/packed_byte_checker.sv @@
// ----------------------------------------------------------------------------
// packed_byte_checker
// Watches both channels of the bit packer, keeps its own code table and
// pending byte, predicts every output byte and compares it field by field.
// ----------------------------------------------------------------------------
module packed_byte_checker #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic  clk,
  input  logic  rst,
  hcbp_in_if    mon_in,
  hcbp_out_if   mon_out,
  output int    fail_count,
  output int    bytes_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import hcbp_pkg::*;

  localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam logic [2:0] TOP_BIT = 3'd7;

  typedef struct packed {
    logic [BYTE_W-1:0] packed_byte;
    logic [PAD_W-1:0]  pad_bits;
    logic              last;
  } packed_result_t;

  logic [LEN_W-1:0]  code_len_mem [256];
  logic [CODE_W-1:0] code_val_mem [256];
  logic [BYTE_W-1:0] pend_byte;
  logic [2:0]        free_pos;
  packed_result_t    expected_bytes [$];

  initial begin
    fail_count = 0;
    bytes_owed = 0;
  end

  task automatic pack_code_word(input logic [KIND_W-1:0] kind_in,
                                input logic [SYMBOL_W-1:0] sym,
                                input logic [LEN_W-1:0] len_in,
                                input logic [CODE_W-1:0] bits);
    int i;
    int produced;
    packed_result_t res;
    produced = 0;
    case (kind_in)
      KIND_LOAD: begin
        code_len_mem[sym] = (len_in > LEN_CAP) ? LEN_W'(LEN_CAP) : len_in;
        code_val_mem[sym] = bits;
      end
      KIND_ENCODE: begin
        for (i = code_len_mem[sym]; i > 0; i--) begin
          if (code_val_mem[sym][i-1]) pend_byte[free_pos] = 1'b1;
          if (free_pos == 3'd0) begin
            res.packed_byte = pend_byte;
            res.pad_bits = '0;
            res.last = 1'b0;
            expected_bytes.push_back(res);
            produced++;
            pend_byte = '0;
            free_pos = TOP_BIT;
          end else begin
            free_pos = free_pos - 3'd1;
          end
        end
        if (produced > 0) expected_bytes[expected_bytes.size()-1].last = 1'b1;
      end
      KIND_FLUSH: begin
        if (free_pos < TOP_BIT) begin
          res.packed_byte = pend_byte;
          res.pad_bits = free_pos + 3'd1;
          res.last = 1'b1;
          expected_bytes.push_back(res);
          pend_byte = '0;
          free_pos = TOP_BIT;
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    packed_result_t want;
    if (rst) begin
      for (int s = 0; s < 256; s++) code_len_mem[s] = '0;
      pend_byte = '0;
      free_pos = TOP_BIT;
      expected_bytes.delete();
    end else begin
      if (mon_in.valid && mon_in.ready)
        pack_code_word(mon_in.kind, mon_in.symbol, mon_in.code_length, mon_in.code_bits);
      if (mon_out.valid && mon_out.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected output word: packed_byte %0h pad_bits %0d last %0b",
                 mon_out.packed_byte, mon_out.pad_bits, mon_out.last);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (mon_out.packed_byte !== want.packed_byte) begin
            $error("packed_byte mismatch: expected %0h, actual %0h",
                   want.packed_byte, mon_out.packed_byte);
            fail_count++;
          end
          if (mon_out.pad_bits !== want.pad_bits) begin
            $error("pad_bits mismatch: expected %0d, actual %0d",
                   want.pad_bits, mon_out.pad_bits);
            fail_count++;
          end
          if (mon_out.last !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, mon_out.last);
            fail_count++;
          end
        end
      end
    end
    bytes_owed = expected_bytes.size();
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the bit packer: directed table loads, encodes and flushes,
// then random traffic with bursty input, a stalling output and long holds.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hcbp_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 310;
  localparam int POOL_SIZE = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 24;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_SPARSE
  } stall_mode_t;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   bytes_owed;
  int   burst_left = 0;
  bit   hold_req = 1'b0;

  hcbp_in_if  in_ch ();
  hcbp_out_if out_ch ();

  huffman_code_bit_packer uut (
    .clk     (clk),
    .rst     (rst),
    .items   (in_ch),
    .results (out_ch)
  );

  packed_byte_checker chk (
    .clk        (clk),
    .rst        (rst),
    .mon_in     (in_ch),
    .mon_out    (out_ch),
    .fail_count (fail_count),
    .bytes_owed (bytes_owed)
  );

  always #5 clk = ~clk;

  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [SYMBOL_W-1:0] sym,
                           input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] bits);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 9) == 0) gap = $urandom_range(15, 25);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= kind;
    in_ch.symbol      <= sym;
    in_ch.code_length <= len;
    in_ch.code_bits   <= bits;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r < 3) return LEN_W'($urandom_range(33, 63));
    if (r < 6) return LEN_W'($urandom_range(13, 32));
    return LEN_W'($urandom_range(1, 12));
  endfunction

  // output side stall patterns
  initial begin : receiver
    int seg_len, period, k;
    stall_mode_t mode;
    out_ch.ready <= 1'b0;
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        mode = stall_mode_t'($urandom_range(0, 3));
        seg_len = $urandom_range(8, 60);
        period = $urandom_range(2, 6);
        for (k = 0; k < seg_len && !hold_req; k++) begin
          case (mode)
            STALL_NONE:     out_ch.ready <= 1'b1;
            STALL_RANDOM:   out_ch.ready <= 1'($urandom_range(0, 1));
            STALL_PERIODIC: out_ch.ready <= (k % period == 0);
            default:        out_ch.ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("huffman_code_bit_packer verification failed");
    $finish;
  end

  initial begin : stimulus
    int i, counted, pick;
    logic [SYMBOL_W-1:0] sym;
    logic [SYMBOL_W-1:0] pool [POOL_SIZE];
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= KIND_LOAD;
    in_ch.symbol      <= '0;
    in_ch.code_length <= '0;
    in_ch.code_bits   <= '0;
    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, table edge cases, longest codes, padding
    send_word(KIND_ENCODE, 8'h00, 6'd0, 32'h0);
    send_word(KIND_FLUSH, 8'h00, 6'd0, 32'h0);
    send_word(KIND_LOAD, 8'h00, 6'd1, 32'h0000_0001);
    send_word(KIND_LOAD, 8'hff, 6'd32, 32'hffff_ffff);
    send_word(KIND_LOAD, 8'h55, 6'd40, 32'ha5a5_a5a5);
    send_word(KIND_LOAD, 8'haa, 6'd0, 32'hdead_beef);
    send_word(KIND_LOAD, 8'h12, 6'd3, 32'hffff_fffd);
    send_word(KIND_LOAD, 8'h34, 6'd63, 32'h0000_0000);
    send_word(KIND_UNUSED, 8'hff, 6'd63, 32'hffff_ffff);
    send_word(KIND_ENCODE, 8'h00, 6'd63, 32'hffff_ffff);
    send_word(KIND_ENCODE, 8'hff, 6'd0, 32'h0);
    send_word(KIND_FLUSH, 8'hff, 6'd63, 32'hffff_ffff);
    send_word(KIND_ENCODE, 8'haa, 6'd0, 32'h0);
    send_word(KIND_ENCODE, 8'h12, 6'd0, 32'h0);
    send_word(KIND_ENCODE, 8'h55, 6'd0, 32'h0);
    send_word(KIND_FLUSH, 8'h00, 6'd0, 32'h0);
    send_word(KIND_ENCODE, 8'hff, 6'd0, 32'h0);
    send_word(KIND_ENCODE, 8'h34, 6'd0, 32'h0);
    send_word(KIND_ENCODE, 8'h00, 6'd0, 32'h0);
    send_word(KIND_ENCODE, 8'h34, 6'd0, 32'h0);
    send_word(KIND_FLUSH, 8'h00, 6'd0, 32'h0);
    send_word(KIND_ENCODE, 8'h7e, 6'd0, 32'h0);
    send_word(KIND_FLUSH, 8'h00, 6'd0, 32'h0);

    // random: fill a small symbol pool, then mostly encode from it
    for (i = 0; i < POOL_SIZE; i++) begin
      pool[i] = SYMBOL_W'($urandom_range(0, 255));
      send_word(KIND_LOAD, pool[i], pick_length(), $urandom);
    end
    counted = POOL_SIZE;
    while (counted < RANDOM_WORDS) begin
      if (counted == 40 || counted == 180) hold_req = 1'b1;
      pick = $urandom_range(0, 99);
      sym = ($urandom_range(0, 4) != 0) ? pool[$urandom_range(0, POOL_SIZE-1)]
                                        : SYMBOL_W'($urandom_range(0, 255));
      if (pick < 60) begin
        send_word(KIND_ENCODE, sym, LEN_W'($urandom_range(0, 63)), $urandom);
        counted++;
      end else if (pick < 80) begin
        send_word(KIND_LOAD, sym, pick_length(), $urandom);
        counted++;
      end else if (pick < 96) begin
        send_word(KIND_FLUSH, sym, LEN_W'($urandom_range(0, 63)), $urandom);
        counted++;
      end else begin
        send_word(KIND_UNUSED, sym, LEN_W'($urandom_range(0, 63)), $urandom);
      end
    end
    in_ch.valid <= 1'b0;

    // let the checker take in the last word before reading its backlog
    @(posedge clk);
    while (bytes_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && bytes_owed == 0) begin
      $display("huffman_code_bit_packer verification clean");
    end else begin
      $display("huffman_code_bit_packer verification failed");
    end
    $finish;
  end

endmodule
